// File: hdl/bkl_pkg.sv
`timescale 1ns / 1ps

package bkl_pkg;

  // Longest word that is still judged as a keyword
  localparam int unsigned MaxWordLen = 15;
  localparam int unsigned WordLenW   = $clog2(MaxWordLen + 1);

  // Token kinds
  localparam logic [2:0] KindOpen  = 3'd0;
  localparam logic [2:0] KindClose = 3'd1;
  localparam logic [2:0] KindBegin = 3'd2;
  localparam logic [2:0] KindEnd   = 3'd3;
  localparam logic [2:0] KindError = 3'd4;
  localparam logic [2:0] KindEos   = 3'd5;

  // Token queue (depth must be a power of two)
  localparam int unsigned TokDepth = 4;
  localparam int unsigned TokPtrW  = $clog2(TokDepth);
  localparam int unsigned TokCntW  = $clog2(TokDepth + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic       last;
  } tok_entry_t;

  // Up to two tokens written into the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    tok_entry_t first;
    tok_entry_t second;
  } tok_push_t;

endpackage

// File: hdl/bkl_if.sv
`timescale 1ns / 1ps

interface bkl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_stream;

  modport source (output valid, output char_byte, output end_of_stream, input ready);
  modport sink (input valid, input char_byte, input end_of_stream, output ready);
endinterface

interface bkl_tok_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic       last_of_run;

  modport source (output valid, output token_kind, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input last_of_run, output ready);
endinterface

// File: hdl/bkl_scan.sv
`timescale 1ns / 1ps

module bkl_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  bkl_byte_if.sink          byte_i,
  input  logic              room_i,
  output bkl_pkg::tok_push_t push_o
);

  localparam int unsigned LenW = bkl_pkg::WordLenW;

  // Scan modes
  localparam logic [2:0] ModeNormal  = 3'd0;
  localparam logic [2:0] ModeString  = 3'd1;
  localparam logic [2:0] ModeEscape  = 3'd2;
  localparam logic [2:0] ModeComment = 3'd3;
  localparam logic [2:0] ModeWord    = 3'd4;
  localparam logic [2:0] ModeSkip    = 3'd5;

  // Characters of interest
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChTab        = 8'h09;
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChQuote      = 8'h27;
  localparam logic [7:0] ChBackslash  = 8'h5C;
  localparam logic [7:0] ChOpenBrace  = 8'h7B;
  localparam logic [7:0] ChCloseBrace = 8'h7D;
  localparam logic [7:0] ChOpenParen  = 8'h28;
  localparam logic [7:0] ChCloseParen = 8'h29;

  function automatic logic is_word_byte(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h7A) || c == 8'h5F || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] begin_char(input logic [LenW-1:0] idx);
    logic [7:0] ch;
    case (idx)
      LenW'(0): ch = 8'h62;
      LenW'(1): ch = 8'h65;
      LenW'(2): ch = 8'h67;
      LenW'(3): ch = 8'h69;
      LenW'(4): ch = 8'h6E;
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] end_char(input logic [LenW-1:0] idx);
    logic [7:0] ch;
    case (idx)
      LenW'(0): ch = 8'h65;
      LenW'(1): ch = 8'h6E;
      LenW'(2): ch = 8'h64;
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

  logic            vld_q;
  logic [7:0]      c_q;
  logic            eos_q;
  logic            advance;

  logic [2:0]      mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;
  logic            mb_q, mb_d;
  logic            me_q, me_d;

  logic [7:0]      fold;
  logic            word_byte;
  logic            sn_vld, sn_word;
  logic [2:0]      sn_kind, sn_mode;
  logic            j_vld;
  logic [2:0]      j_kind;
  logic            a_vld, b_vld;
  logic [2:0]      a_kind, b_kind;

  // Input register: take a byte whenever it is empty or the held one moves on
  assign advance      = vld_q && room_i;
  assign byte_i.ready = !vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      c_q   <= byte_i.char_byte;
      eos_q <= byte_i.end_of_stream;
    end
  end

  // Classify the byte as seen from normal mode
  always_comb begin
    fold      = fold_case(c_q);
    word_byte = is_word_byte(c_q);
    sn_vld    = 1'b0;
    sn_word   = 1'b0;
    sn_kind   = bkl_pkg::KindOpen;
    sn_mode   = ModeNormal;
    if (c_q == ChSpace || c_q == ChTab || c_q == ChNewline) begin
      sn_mode = ModeNormal;
    end else if (c_q == ChQuote) begin
      sn_mode = ModeString;
    end else if (c_q == ChCloseBrace) begin
      sn_vld  = 1'b1;
      sn_kind = bkl_pkg::KindError;
    end else if (c_q == ChOpenBrace) begin
      sn_mode = ModeComment;
    end else if (c_q == ChOpenParen) begin
      sn_vld  = 1'b1;
      sn_kind = bkl_pkg::KindOpen;
    end else if (c_q == ChCloseParen) begin
      sn_vld  = 1'b1;
      sn_kind = bkl_pkg::KindClose;
    end else if (word_byte) begin
      sn_word = 1'b1;
      sn_mode = ModeWord;
    end
  end

  // Judge the word held so far
  always_comb begin
    j_vld  = (mode_q == ModeWord) &&
             ((mb_q && len_q == LenW'(5)) || (me_q && len_q == LenW'(3)));
    j_kind = (mb_q && len_q == LenW'(5)) ? bkl_pkg::KindBegin : bkl_pkg::KindEnd;
  end

  // Mode update and token selection
  always_comb begin
    mode_d = mode_q;
    len_d  = len_q;
    mb_d   = mb_q;
    me_d   = me_q;
    a_vld  = 1'b0;
    a_kind = bkl_pkg::KindOpen;
    b_vld  = 1'b0;
    b_kind = bkl_pkg::KindOpen;
    if (eos_q) begin
      if (mode_q == ModeString || mode_q == ModeEscape || mode_q == ModeComment) begin
        a_vld  = 1'b1;
        a_kind = bkl_pkg::KindError;
      end else begin
        a_vld  = j_vld;
        a_kind = j_kind;
      end
      b_vld  = 1'b1;
      b_kind = bkl_pkg::KindEos;
      mode_d = ModeNormal;
      len_d  = '0;
      mb_d   = 1'b1;
      me_d   = 1'b1;
    end else begin
      unique case (mode_q)
        ModeString: begin
          if (c_q == ChQuote) begin
            mode_d = ModeNormal;
          end else if (c_q == ChBackslash) begin
            mode_d = ModeEscape;
          end
        end
        ModeEscape: begin
          mode_d = ModeString;
        end
        ModeComment: begin
          if (c_q == ChCloseBrace) begin
            mode_d = ModeNormal;
          end
        end
        ModeWord, ModeSkip: begin
          if (word_byte) begin
            if (mode_q == ModeWord) begin
              if (len_q < LenW'(bkl_pkg::MaxWordLen)) begin
                mb_d  = mb_q && (len_q < LenW'(5)) && (begin_char(len_q) == fold);
                me_d  = me_q && (len_q < LenW'(3)) && (end_char(len_q) == fold);
                len_d = len_q + LenW'(1);
              end else begin
                mode_d = ModeSkip;
              end
            end
          end else begin
            // Close the word, then rescan the ending byte
            a_vld  = j_vld;
            a_kind = j_kind;
            b_vld  = sn_vld;
            b_kind = sn_kind;
            mode_d = sn_mode;
            if (sn_word) begin
              len_d = LenW'(1);
              mb_d  = (begin_char('0) == fold);
              me_d  = (end_char('0) == fold);
            end else begin
              len_d = '0;
              mb_d  = 1'b1;
              me_d  = 1'b1;
            end
          end
        end
        default: begin
          b_vld  = sn_vld;
          b_kind = sn_kind;
          mode_d = sn_mode;
          if (sn_word) begin
            len_d = LenW'(1);
            mb_d  = (begin_char('0) == fold);
            me_d  = (end_char('0) == fold);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      len_q  <= '0;
      mb_q   <= 1'b1;
      me_q   <= 1'b1;
    end else if (advance) begin
      mode_q <= mode_d;
      len_q  <= len_d;
      mb_q   <= mb_d;
      me_q   <= me_d;
    end
  end

  // Pack the tokens in order; the final one carries the last flag
  always_comb begin
    push_o.second.kind = b_kind;
    push_o.second.last = 1'b1;
    if (a_vld && b_vld) begin
      push_o.count      = 2'd2;
      push_o.first.kind = a_kind;
      push_o.first.last = 1'b0;
    end else begin
      push_o.count      = (a_vld || b_vld) ? 2'd1 : 2'd0;
      push_o.first.kind = a_vld ? a_kind : b_kind;
      push_o.first.last = 1'b1;
    end
    if (!advance) begin
      push_o.count = 2'd0;
    end
  end

endmodule

// File: hdl/bkl_tok_fifo.sv
`timescale 1ns / 1ps

module bkl_tok_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bkl_pkg::tok_push_t push_i,
  output logic               room_o,
  bkl_tok_if.source          tok_o
);

  localparam int unsigned PtrW = bkl_pkg::TokPtrW;
  localparam int unsigned CntW = bkl_pkg::TokCntW;

  bkl_pkg::tok_entry_t ent_q [bkl_pkg::TokDepth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                pop;

  assign pop               = tok_o.valid && tok_o.ready;
  assign tok_o.valid       = count_q != '0;
  assign tok_o.token_kind  = ent_q[rd_ptr_q].kind;
  assign tok_o.last_of_run = ent_q[rd_ptr_q].last;

  // Room for a full pair of tokens
  assign room_o = count_q <= CntW'(bkl_pkg::TokDepth - 2);

  // Store pushed tokens
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      ent_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      ent_q[wr_ptr_q + PtrW'(1)] <= push_i.second;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(push_i.count) - CntW'(pop);
    end
  end

endmodule

// File: hdl/block_keyword_lexer_unit.sv
`timescale 1ns / 1ps

// Keyword lexer for a Pascal-like source.
// byte_i takes one source byte per transfer (char_byte), or an end-of-stream
// mark (end_of_stream set, char_byte ignored). token_o gives the tokens:
// open/close paren, begin, end, error and end of stream; last_of_run marks
// the final token that a byte caused. A byte causes zero, one or two tokens.
// A byte is held in the input register; then its tokens are written into
// the token queue, from whose head token_o offers them.
// Throughput: one byte per cycle while the queue has room for two tokens;
// a byte that gives two tokens needs two transfers on token_o, since token_o
// moves one token per cycle. The four-entry token queue sets how far the
// input runs ahead of the output: a byte leaves the input register only
// while the queue has room for two.
// Reset clears the scan state to normal mode and empties the queue; the
// first byte after reset starts a fresh source.
// When the receiver stalls, the token at the head holds, the queue fills,
// and byte_i.ready drops until room for two tokens is free again.
module block_keyword_lexer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  bkl_byte_if.sink  byte_i,
  bkl_tok_if.source token_o
);

  bkl_pkg::tok_push_t push;
  logic               room;

  bkl_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .room_i (room),
    .push_o (push)
  );

  bkl_tok_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .tok_o  (token_o)
  );

endmodule

// File: hdl/bkl_checker.sv
`timescale 1ns / 1ps

module bkl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tok_valid_i,
  input logic       tok_ready_i,
  input logic [2:0] tok_kind_i,
  input logic       tok_last_i
);

  // Hold a stalled token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && !tok_ready_i |=> tok_valid_i && $stable(tok_kind_i) && $stable(tok_last_i))
    else $error("stalled token changed");

  // End of stream always closes a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_kind_i == bkl_pkg::KindEos |-> tok_last_i)
    else $error("end-of-stream token not last of run");

  // The first of a pair is a keyword or an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && !tok_last_i |->
      tok_kind_i == bkl_pkg::KindBegin || tok_kind_i == bkl_pkg::KindEnd ||
      tok_kind_i == bkl_pkg::KindError)
    else $error("unexpected first token of a pair");

  // The second of a pair follows at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i && tok_ready_i && !tok_last_i |=> tok_valid_i)
    else $error("gap inside a token pair");

endmodule

bind block_keyword_lexer_unit bkl_checker u_bkl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .tok_valid_i (token_o.valid),
  .tok_ready_i (token_o.ready),
  .tok_kind_i  (token_o.token_kind),
  .tok_last_i  (token_o.last_of_run)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

package lexer_tb_pkg;

  // Scanner modes of the predictor
  typedef enum logic [2:0] {
    ScanNormal  = 3'd0,
    ScanString  = 3'd1,
    ScanEscape  = 3'd2,
    ScanComment = 3'd3,
    ScanWord    = 3'd4,
    ScanSkip    = 3'd5
  } scan_mode_e;

  // Source bytes with a meaning of their own
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChLbrace    = 8'h7b;
  localparam logic [7:0] ChRbrace    = 8'h7d;
  localparam logic [7:0] ChLparen    = 8'h28;
  localparam logic [7:0] ChRparen    = 8'h29;

  // Token predictor and queue of expected tokens
  class lexer_scoreboard;
    scan_mode_e          mode;
    logic [4:0]          word_len;
    bit                  maybe_begin;
    bit                  maybe_end;
    bkl_pkg::tok_entry_t expected_tokens[$];
    bkl_pkg::tok_entry_t run_tokens[$];
    string               kw_begin;
    string               kw_end;

    function new();
      kw_begin = "begin";
      kw_end   = "end";
      mode     = ScanNormal;
      clear_word();
    endfunction

    function void clear_word();
      word_len    = '0;
      maybe_begin = 1'b1;
      maybe_end   = 1'b1;
    endfunction

    function bit is_word_char(logic [7:0] c);
      return (c >= "A" && c <= "z") || c == "_" || (c >= "0" && c <= "9");
    endfunction

    function void push_kind(logic [2:0] k);
      bkl_pkg::tok_entry_t t;
      t.kind = k;
      t.last = 1'b0;
      if (run_tokens.size() < 2) run_tokens.push_back(t);
    endfunction

    // Fold case and narrow the keyword candidates
    function void add_char(logic [7:0] c);
      logic [7:0] f;
      f = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      if (word_len >= 5 || kw_begin[word_len] != f) maybe_begin = 1'b0;
      if (word_len >= 3 || kw_end[word_len] != f) maybe_end = 1'b0;
      word_len = word_len + 5'd1;
    endfunction

    // Judge the finished word and go back to normal scanning
    function void close_word();
      if (mode == ScanWord) begin
        if (maybe_begin && word_len == 5) push_kind(bkl_pkg::KindBegin);
        else if (maybe_end && word_len == 3) push_kind(bkl_pkg::KindEnd);
      end
      mode = ScanNormal;
      clear_word();
    endfunction

    function void scan_plain(logic [7:0] c);
      if (c == ChSpace || c == ChTab || c == ChNewline) return;
      if (c == ChQuote) mode = ScanString;
      else if (c == ChRbrace) push_kind(bkl_pkg::KindError);
      else if (c == ChLbrace) mode = ScanComment;
      else if (c == ChLparen) push_kind(bkl_pkg::KindOpen);
      else if (c == ChRparen) push_kind(bkl_pkg::KindClose);
      else if (is_word_char(c)) begin
        clear_word();
        add_char(c);
        mode = ScanWord;
      end
    endfunction

    // Advance the predictor by one accepted byte and queue its tokens
    function void note_byte(logic [7:0] c, logic eos);
      run_tokens.delete();
      if (eos) begin
        if (mode == ScanString || mode == ScanEscape || mode == ScanComment)
          push_kind(bkl_pkg::KindError);
        else if (mode == ScanWord || mode == ScanSkip)
          close_word();
        mode = ScanNormal;
        clear_word();
        push_kind(bkl_pkg::KindEos);
      end else begin
        case (mode)
          ScanString: begin
            if (c == ChQuote) mode = ScanNormal;
            else if (c == ChBackslash) mode = ScanEscape;
          end
          ScanEscape: mode = ScanString;
          ScanComment: begin
            if (c == ChRbrace) mode = ScanNormal;
          end
          ScanWord, ScanSkip: begin
            if (is_word_char(c)) begin
              if (mode == ScanWord) begin
                if (word_len < bkl_pkg::MaxWordLen) add_char(c);
                else mode = ScanSkip;
              end
            end else begin
              close_word();
              scan_plain(c);
            end
          end
          default: begin
            mode = ScanNormal;
            scan_plain(c);
          end
        endcase
      end
      if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last = 1'b1;
      foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    // Compare one transferred token with the oldest expectation
    function string check_token(logic [2:0] kind, logic last);
      bkl_pkg::tok_entry_t want;
      if (expected_tokens.size() == 0)
        return $sformatf("token kind %0d last %0b with none expected", kind, last);
      want = expected_tokens.pop_front();
      if (kind !== want.kind || last !== want.last)
        return $sformatf("token kind %0d last %0b, expected kind %0d last %0b",
                         kind, last, want.kind, want.last);
      return "";
    endfunction
  endclass

endpackage

module tb;

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   hold_request;
  int   err_count;
  int   items_sent;

  lexer_tb_pkg::lexer_scoreboard sb;

  bkl_byte_if byte_bus ();
  bkl_tok_if  tok_bus ();

  block_keyword_lexer_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_bus),
    .token_o(tok_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("block_keyword_lexer_unit regression: fail");
    $finish;
  end

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Offer one byte from a falling edge, hold it until the transfer
  task automatic send_item(input logic [7:0] c, input logic eos);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      byte_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    byte_bus.valid         <= 1'b1;
    byte_bus.char_byte     <= c;
    byte_bus.end_of_stream <= eos;
    do @(posedge clk); while (!byte_bus.ready);
    sb.note_byte(c, eos);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eos();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_word_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(48, 57));
    return 8'($urandom_range(65, 122));
  endfunction

  // Send one lexical fragment with random content
  task automatic send_fragment();
    string kw;
    int    n;
    logic [7:0] c;
    case ($urandom_range(0, 15))
      0, 1, 2: begin
        kw = $urandom_range(0, 1) ? "begin" : "end";
        for (int i = 0; i < kw.len(); i++) begin
          c = kw[i];
          if ($urandom_range(0, 1)) c = c - 8'd32;
          send_item(c, 1'b0);
        end
      end
      3, 4: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
        repeat (n) send_item(rand_word_char(), 1'b0);
      end
      5: begin
        case ($urandom_range(0, 2))
          0: send_item(lexer_tb_pkg::ChSpace, 1'b0);
          1: send_item(lexer_tb_pkg::ChTab, 1'b0);
          default: send_item(lexer_tb_pkg::ChNewline, 1'b0);
        endcase
      end
      6: send_item($urandom_range(0, 1) ? lexer_tb_pkg::ChLparen : lexer_tb_pkg::ChRparen,
                   1'b0);
      7: begin
        send_item(lexer_tb_pkg::ChQuote, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) send_item(lexer_tb_pkg::ChBackslash, 1'b0);
          send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        send_item(lexer_tb_pkg::ChQuote, 1'b0);
      end
      8: begin
        send_item(lexer_tb_pkg::ChLbrace, 1'b0);
        repeat ($urandom_range(0, 5)) send_item(8'($urandom_range(0, 255)), 1'b0);
        send_item(lexer_tb_pkg::ChRbrace, 1'b0);
      end
      9: send_item(lexer_tb_pkg::ChRbrace, 1'b0);
      10: send_item(8'($urandom_range(0, 255)), 1'b0);
      11: begin
        if ($urandom_range(0, 2) == 0) send_eos();
        else send_item(lexer_tb_pkg::ChSpace, 1'b0);
      end
      default: begin
        if ($urandom_range(0, 1)) send_item(lexer_tb_pkg::ChSpace, 1'b0);
        else send_item($urandom_range(0, 1) ? lexer_tb_pkg::ChLparen
                                           : lexer_tb_pkg::ChRparen, 1'b0);
      end
    endcase
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    tok_bus.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        tok_bus.ready <= 1'b0;
        repeat (80) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        tok_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        tok_bus.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Check every transferred token
  always @(posedge clk) begin : token_monitor
    string msg;
    if (rst_n && tok_bus.valid && tok_bus.ready) begin
      msg = sb.check_token(tok_bus.token_kind, tok_bus.last_of_run);
      if (msg.len() != 0) report(msg);
    end
  end

  // Sender and run control
  initial begin
    byte_bus.valid         = 1'b0;
    byte_bus.char_byte     = '0;
    byte_bus.end_of_stream = 1'b0;
    rst_n                  = 1'b0;
    idle_on                = 1'b1;
    hold_request           = 1'b0;
    err_count              = 0;
    items_sent             = 0;
    sb                     = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: keywords ended by parens, stray brace, open comment and
    // escape at end of stream, word at end of stream, repeated end, odd bytes
    send_text("begin(");
    send_text("End)");
    send_text("}");
    send_text("{");
    send_eos();
    send_item(lexer_tb_pkg::ChQuote, 1'b0);
    send_item(lexer_tb_pkg::ChBackslash, 1'b0);
    send_eos();
    send_text("end");
    send_eos();
    send_eos();
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(lexer_tb_pkg::ChTab, 1'b0);
    send_item(lexer_tb_pkg::ChNewline, 1'b0);
    wait_drained();

    // Fill the token queue while the receiver holds off
    hold_request = 1'b1;
    repeat (30) begin
      send_item($urandom_range(0, 1) ? lexer_tb_pkg::ChLparen : lexer_tb_pkg::ChRparen,
                1'b0);
    end

    while (items_sent < 250) send_fragment();
    wait_drained();
    while (items_sent < 340) send_fragment();

    // Finish at full rate
    idle_on = 1'b0;
    while (items_sent < 400) send_fragment();
    byte_bus.valid <= 1'b0;

    wait_drained();
    repeat (20) @(negedge clk);
    if (sb.pending() != 0) report("expected tokens left over at end");
    if (err_count == 0) begin
      $display("block_keyword_lexer_unit regression: pass");
    end else begin
      $display("block_keyword_lexer_unit regression: fail");
    end
    $finish;
  end

endmodule
